// ----- design/spaq_pkg.sv -----
package spaq_pkg;

   localparam int unsigned SPAQ_DEPTH = 16;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W = 5;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CMP,
      ST_INS_PLACE,
      ST_DEQ_READ,
      ST_DEQ_MOVE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                      start;
      logic                      req_type;
      logic signed [VALUE_W-1:0] value;
      logic                      ack;
   } cmd_type;

   typedef struct packed {
      logic                      idle;
      logic                      done;
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic [OCC_W-1:0]          occupancy;
   } result_type;

endpackage

// ----- design/spaq_core.sv -----
module spaq_core #(
   parameter int unsigned DEPTH = spaq_pkg::SPAQ_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spaq_pkg::cmd_type    cmd,
   output spaq_pkg::result_type result
);
   import spaq_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] out_ff, out_in;
   status_type                status_ff, status_in;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic [IDX_W-1:0]          rd_addr;

   logic                      full;
   logic                      empty;
   logic                      idx_one;
   logic                      last;
   logic                      shift_down;
   logic [CNT_W+OCC_W-1:0]    occ_wide;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign idx_one    = (idx_ff == IDX_W'(1));
   assign last       = (CNT_W'(CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign shift_down = (rd_data_ff >= value_ff);
   assign occ_wide   = {{OCC_W{1'b0}}, count_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.req_type == REQ_ENQUEUE) begin
                  state_in = (full || empty) ? ST_FINISH : ST_INS_READ;
               end else begin
                  state_in = empty ? ST_FINISH : ST_DEQ_READ;
               end
            end
         end
         ST_INS_READ:  state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            if (shift_down) begin
               state_in = idx_one ? ST_INS_PLACE : ST_INS_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_INS_PLACE: state_in = ST_FINISH;
         ST_DEQ_READ:  state_in = ST_DEQ_MOVE;
         ST_DEQ_MOVE:  state_in = last ? ST_FINISH : ST_DEQ_READ;
         ST_FINISH:    state_in = cmd.ack ? ST_IDLE : ST_FINISH;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      out_in    = out_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = value_ff;
      rd_addr   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               value_in  = cmd.value;
               out_in    = '0;
               status_in = STATUS_OK;
               idx_in    = '0;
               if (cmd.req_type == REQ_ENQUEUE) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else if (empty) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = cmd.value;
                     count_in = CNT_W'(count_ff + CNT_W'(1));
                  end else begin
                     idx_in = count_ff[IDX_W-1:0];
                  end
               end else if (empty) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         ST_INS_READ: begin
            rd_addr = IDX_W'(idx_ff - IDX_W'(1));
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (shift_down) begin
               wr_data = rd_data_ff;
               idx_in  = IDX_W'(idx_ff - IDX_W'(1));
            end else begin
               count_in = CNT_W'(count_ff + CNT_W'(1));
            end
         end
         ST_INS_PLACE: begin
            wr_en    = 1'b1;
            count_in = CNT_W'(count_ff + CNT_W'(1));
         end
         ST_DEQ_MOVE: begin
            if (idx_ff == '0) begin
               out_in = rd_data_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(idx_ff - IDX_W'(1));
               wr_data = rd_data_ff;
            end
            if (last) begin
               count_in = CNT_W'(count_ff - CNT_W'(1));
            end else begin
               idx_in = IDX_W'(idx_ff + IDX_W'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      out_ff    <= out_in;
      status_ff <= status_in;
   end

   assign result.idle      = (state_ff == ST_IDLE);
   assign result.done      = (state_ff == ST_FINISH);
   assign result.status    = status_ff;
   assign result.value     = out_ff;
   assign result.occupancy = occ_wide[OCC_W-1:0];

endmodule

// ----- design/sorted_array_priority_queue_unit.sv -----
// Sorted-array minimum priority queue, up to DEPTH signed 32-bit values.
// Request channel (req_valid/req_ready): req_type 0 enqueues req_in_value,
// 1 dequeues the smallest value. Each request yields one response word on
// rsp_valid/rsp_ready: rsp_status (ok, empty, full), rsp_out_value (the
// value removed, else zero) and rsp_occupancy (count after the request).
// Values stay in ascending order in a single-port-write RAM; one compare
// and move step runs over it, one entry at a time. An enqueue shifts up
// each stored value not smaller than the new one and then writes the new
// value; a dequeue reads out the first entry and moves every other one
// down. An enqueue to an empty or full queue, and a dequeue from an empty
// one, skip the step. The next request is accepted only once the engine is
// idle again, from the cycle after the response word is loaded, so the
// engine never works on two requests at once.
// A finished response sits in an output register; while the receiver
// stalls, the next request may still be accepted and worked on, and the
// engine then holds its result until the output register frees.
// Synchronous reset empties the queue and drops any pending response.
module sorted_array_priority_queue_unit #(
   parameter int unsigned DEPTH = spaq_pkg::SPAQ_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic signed [spaq_pkg::VALUE_W-1:0] req_in_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [spaq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [spaq_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [spaq_pkg::OCC_W-1:0]          rsp_occupancy
);
   import spaq_pkg::*;

   cmd_type                   cmd;
   result_type                result;
   logic                      load;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [OCC_W-1:0]          occ_ff;

   spaq_core #(
      .DEPTH(DEPTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .result(result)
   );

   assign req_ready    = result.idle;
   assign load         = result.done && (!rsp_valid_ff || rsp_ready);

   assign cmd.start    = req_valid && req_ready;
   assign cmd.req_type = req_type;
   assign cmd.value    = req_in_value;
   assign cmd.ack      = load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= result.status;
         value_ff  <= result.value;
         occ_ff    <= result.occupancy;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_value = value_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ----- bench/sorted_array_priority_queue_unit_tb.sv -----
module sorted_array_priority_queue_unit_tb;
   import spaq_pkg::*;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic [OCC_W-1:0]          occupancy;
   } word_type;

   typedef struct packed {
      logic                      rtype;
      logic signed [VALUE_W-1:0] value;
      logic                      fixed;
      status_type                status;
      logic signed [VALUE_W-1:0] out_value;
      logic [OCC_W-1:0]          occupancy;
   } stim_row_type;

   localparam int N_ROWS = 24;
   localparam int N_RANDOM = 1530;
   localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{REQ_DEQUEUE, 32'sh0000_0000, 1'b1, STATUS_EMPTY, 32'sh0, 5'd0},
      '{REQ_ENQUEUE, VMAX,           1'b1, STATUS_OK,    32'sh0, 5'd1},
      '{REQ_ENQUEUE, VMIN,           1'b1, STATUS_OK,    32'sh0, 5'd2},
      '{REQ_DEQUEUE, 32'sh0000_0000, 1'b1, STATUS_OK,    VMIN,   5'd1},
      '{REQ_ENQUEUE, 32'sh0000_0000, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'shffff_ffff, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0001, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0005, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0005, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0005, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, VMIN,           1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, VMAX,           1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'shffff_fffb, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0064, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh5555_5555, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'shaaaa_aaaa, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0003, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0003, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_0007, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_ENQUEUE, 32'sh0000_002a, 1'b1, STATUS_FULL,  32'sh0, 5'd16},
      '{REQ_ENQUEUE, VMIN,           1'b1, STATUS_FULL,  32'sh0, 5'd16},
      '{REQ_DEQUEUE, 32'sh0000_0000, 1'b1, STATUS_OK,    VMIN,   5'd15},
      '{REQ_DEQUEUE, 32'sh0000_0000, 1'b0, STATUS_OK,    32'sh0, 5'd0},
      '{REQ_DEQUEUE, 32'shffff_ffff, 1'b0, STATUS_OK,    32'sh0, 5'd0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_type;
   logic signed [VALUE_W-1:0] req_in_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [OCC_W-1:0]          rsp_occupancy;

   logic signed [VALUE_W-1:0] model_entries [$];
   word_type                  expected_words [$];
   int                        error_count;
   int                        n_enqueue;
   int                        n_dequeue;
   int                        n_full;
   int                        n_empty;
   int                        stall_left;
   bit                        calm;

   sorted_array_priority_queue_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_in_value  (req_in_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(10 * 1_000_000);
      $display("TEST FAILED");
      $finish;
   end

   function automatic word_type predict_queue_op(input logic rtype,
                                                 input logic signed [VALUE_W-1:0] value);
      word_type w;
      int       pos;
      w.status = STATUS_OK;
      w.value = '0;
      if (rtype == REQ_ENQUEUE) begin
         n_enqueue++;
         if (model_entries.size() >= SPAQ_DEPTH) begin
            w.status = STATUS_FULL;
            n_full++;
         end else begin
            pos = 0;
            while (pos < model_entries.size() && model_entries[pos] < value) pos++;
            model_entries.insert(pos, value);
         end
      end else begin
         n_dequeue++;
         if (model_entries.size() == 0) begin
            w.status = STATUS_EMPTY;
            n_empty++;
         end else begin
            w.value = model_entries.pop_front();
         end
      end
      w.occupancy = OCC_W'(model_entries.size());
      return w;
   endfunction

   task automatic send_word(input logic rtype, input logic signed [VALUE_W-1:0] value,
                            input logic fixed, input word_type typed);
      word_type w;
      int       gap;
      if (!calm && $urandom_range(99) < 36) begin
         gap = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= rtype;
      req_in_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      w = predict_queue_op(rtype, value);
      expected_words.push_back(fixed ? typed : w);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return ($urandom_range(1) != 0) ? VMIN : VMAX;
         1: return ($urandom_range(1) != 0) ? 32'sh0 : 32'shffff_ffff;
         2, 3, 4: return $signed($urandom_range(16)) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   initial begin
      word_type typed;
      int       enq_pct;
      logic     rtype;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = REQ_ENQUEUE;
      req_in_value = '0;
      calm         = 1'b0;
      error_count  = 0;
      n_enqueue    = 0;
      n_dequeue    = 0;
      n_full       = 0;
      n_empty      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         typed.status    = DIRECTED_ROWS[i].status;
         typed.value     = DIRECTED_ROWS[i].out_value;
         typed.occupancy = DIRECTED_ROWS[i].occupancy;
         send_word(DIRECTED_ROWS[i].rtype, DIRECTED_ROWS[i].value,
                   DIRECTED_ROWS[i].fixed, typed);
      end

      enq_pct = 50;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: enq_pct = 15;
               1: enq_pct = 50;
               default: enq_pct = 85;
            endcase
         end
         calm  = (i >= 600 && i < 900);
         rtype = ($urandom_range(99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
         send_word(rtype, pick_value(), 1'b0, typed);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d requests: %0d enqueues (%0d rejected full), %0d dequeues (%0d empty).",
               n_enqueue + n_dequeue, n_enqueue, n_full, n_dequeue, n_empty);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      word_type w;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response word: status %0d out_value %0d occupancy %0d",
                      rsp_status, rsp_out_value, rsp_occupancy);
               error_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_status !== w.status) begin
                  $error("rsp_status expected %0d actual %0d", w.status, rsp_status);
                  error_count++;
               end
               if (rsp_out_value !== w.value) begin
                  $error("rsp_out_value expected %0d actual %0d", w.value, rsp_out_value);
                  error_count++;
               end
               if (rsp_occupancy !== w.occupancy) begin
                  $error("rsp_occupancy expected %0d actual %0d", w.occupancy, rsp_occupancy);
                  error_count++;
               end
            end
         end
         if (calm) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(199) == 0) begin
            stall_left = $urandom_range(20, 60);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 23);
         end
      end
   end

endmodule

// ----- sorted_array_priority_queue_unit.f -----
design/spaq_pkg.sv
design/spaq_core.sv
design/sorted_array_priority_queue_unit.sv
bench/sorted_array_priority_queue_unit_tb.sv
